[rtl/nearest_smaller_to_left_unit_assert.svh]
// Assertion macros used by the nearest_smaller_to_left_unit RTL.
`ifndef NEAREST_SMALLER_TO_LEFT_UNIT_ASSERT_SVH
`define NEAREST_SMALLER_TO_LEFT_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check, held off while reset is high.
`define NSLT_ASSERT(label, ck, rs, prop) \
  label: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("nslt: check failed");
// Clocked check, also active during reset.
`define NSLT_ASSERT_ALWAYS(label, ck, prop) \
  label: assert property (@(posedge ck) prop) \
    else $error("nslt: check failed");
`else
`define NSLT_ASSERT(label, ck, rs, prop)
`define NSLT_ASSERT_ALWAYS(label, ck, prop)
`endif

`endif

[rtl/nslt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package nslt_pkg;
  localparam int STACK_DEPTH_DEF = 64;
  localparam int VALUE_WIDTH_DEF = 32;
endpackage
`default_nettype wire

[rtl/nslt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module nslt_ram
  import nslt_pkg::*;
#(
  parameter int WIDTH = VALUE_WIDTH_DEF,
  parameter int DEPTH = STACK_DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/nearest_smaller_to_left_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Signals                         Contents
// s_axis    in   tvalid tready tdata tlast       value / last_in_array
// m_axis    out  tvalid tready tdata tuser       nearest_smaller / found, overflow
//
// An item is accepted, then compared and pushed; each popped entry adds a
// compare and a stack memory read, but the pop that empties the stack skips the read.
// Each such read refills the cached top of stack from the registered-read stack RAM.
// The result waits in an output register; the compare stalls only when that
// register is still full. rst is synchronous and empties the stack.
`include "nearest_smaller_to_left_unit_assert.svh"
module nearest_smaller_to_left_unit
  import nslt_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int DW = ((VALUE_WIDTH + 7) / 8) * 8,
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [DW-1:0] s_axis_tdata,  // [VALUE_WIDTH-1:0] value
  input  wire logic          s_axis_tlast,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic      [DW-1:0] m_axis_tdata,  // [VALUE_WIDTH-1:0] nearest_smaller
  output logic      [1:0]    m_axis_tuser   // [0] found, [1] overflow
);

  typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_WAIT} state_t;

  state_t                         state;
  logic        [CW-1:0]           count;
  logic signed [VALUE_WIDTH-1:0]  top;
  logic signed [VALUE_WIDTH-1:0]  val;
  logic                           last;

  logic                           pop;
  logic                           out_free;
  logic                           full;
  logic                           emit;
  logic                           we;
  logic        [CW-1:0]           rd_ptr;
  logic        [VALUE_WIDTH-1:0]  rdata;

  assign s_axis_tready = (state == ST_IDLE);
  assign pop      = (count != '0) && (top >= val);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign full     = (count == CW'(STACK_DEPTH));
  assign emit     = (state == ST_CMP) && !pop && out_free;
  assign we       = emit && !full;
  assign rd_ptr   = count - CW'(2);

  nslt_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata (val),
    .raddr (rd_ptr[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            val   <= s_axis_tdata[VALUE_WIDTH-1:0];
            last  <= s_axis_tlast;
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (pop) begin
            count <= count - CW'(1);
            if (count > CW'(1)) begin
              state <= ST_WAIT;
            end
          end else if (out_free) begin
            m_axis_tuser[0] <= (count != '0);
            m_axis_tuser[1] <= full;
            m_axis_tdata    <= (count != '0) ? DW'($unsigned(top)) : '0;
            if (!full) begin
              top <= val;
            end
            if (last) begin
              count <= '0;
            end else if (!full) begin
              count <= count + CW'(1);
            end
            state <= ST_IDLE;
          end
        end
        ST_WAIT: begin
          top   <= rdata;
          state <= ST_CMP;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `NSLT_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> count == '0 && !m_axis_tvalid)
  `NSLT_ASSERT(a_count_bound, clk, rst, count <= CW'(STACK_DEPTH))
  `NSLT_ASSERT(a_accept_to_cmp, clk, rst, s_axis_tvalid && s_axis_tready |=> state == ST_CMP)
  `NSLT_ASSERT(a_wait_after_pop, clk, rst,
    state == ST_WAIT |-> count != '0 && $past(state) == ST_CMP)

endmodule
`default_nettype wire
